[rtl/windowed_event_count_detector_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the windowed event count detector.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_EVENT_COUNT_DETECTOR_CORE_MACROS_SVH
`define WINDOWED_EVENT_COUNT_DETECTOR_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define WECD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WECD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/wecd_pkg.sv]
// ---------------------------------------------------------------------------
// wecd_pkg
// Shared sizes, codes and beat types of the windowed event count detector.
// ---------------------------------------------------------------------------
`default_nettype none

package wecd_pkg;

  localparam int MAX_EVENTS = 16;
  localparam int TIME_BITS  = 32;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);

  localparam int ACT_W      = 3;
  localparam int DT_W       = 16;
  localparam int WIN_W      = 24;
  localparam int REACH_W    = 5;
  localparam int HOLD_W     = 25;
  localparam int EVT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int AGE_CMP_W  = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int CNT_CMP_W  = (CNT_W > REACH_W) ? CNT_W : REACH_W;

  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DROP_NEW  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP_ALL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_START     = 3'd4;
  localparam logic [ACT_W-1:0] ACT_STOP      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [REACH_W-1:0] REACH_RESET = 5'd1;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [DT_W-1:0]  tick_amount;
  } in_t;

  typedef struct packed {
    logic             done_pulse;
    logic             reached;
    logic             running;
    logic [EVT_W-1:0] event_count;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic            tick;
    logic            shift;
    logic [DT_W-1:0] dt;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/wecd_cell.sv]
// ---------------------------------------------------------------------------
// wecd_cell
// One slot of the event chain: holds the age of one stored event.
// ---------------------------------------------------------------------------
`default_nettype none

module wecd_cell (
  input  logic                           clk,
  input  wecd_pkg::cell_ctl_t            ctl,
  input  logic                           wr_en,
  input  logic [wecd_pkg::TIME_BITS-1:0] nbr_age,
  output logic [wecd_pkg::TIME_BITS-1:0] age
);
  import wecd_pkg::*;

  logic [TIME_BITS-1:0] age_r;
  logic [TIME_BITS-1:0] age_nxt;
  logic [TIME_BITS-1:0] base;

  always_comb begin
    base = ctl.shift ? nbr_age : age_r;
    if (wr_en) begin
      age_nxt = '0;
    end else if (ctl.tick) begin
      age_nxt = base + TIME_BITS'(ctl.dt);
    end else begin
      age_nxt = base;
    end
  end

  always_ff @(posedge clk) begin
    age_r <= age_nxt;
  end

  assign age = age_r;

endmodule

`default_nettype wire

[rtl/windowed_event_count_detector_core.sv]
// Result: each accepted input beat yields its result beat in the next cycle.
// Throughput: one item per cycle while out_ready is high; every action
// finishes in a single pass through the cell chain and the control registers.
// Reset: synchronous, active low; clears run, reached, hold and count state
// and loads the register defaults. Stored ages need no reset.
// ---------------------------------------------------------------------------
// windowed_event_count_detector_core
// Event rate detector built as a chain of age cells with an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module windowed_event_count_detector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wecd_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wecd_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wecd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wecd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wecd_pkg::*;

  logic [WIN_W-1:0]     window_r;
  logic [REACH_W-1:0]   reach_r;
  logic                 mode_r;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 running_r, running_nxt;
  logic                 reached_r, reached_nxt;
  logic                 hold_active_r, hold_active_nxt;
  logic [HOLD_W-1:0]    hold_rem_r, hold_rem_nxt;
  logic                 out_valid_r;
  out_t                 out_data_r;

  logic                 accept;
  logic [ACT_W-1:0]     act;
  logic [DT_W-1:0]      dt;
  logic                 tick_go;
  logic                 add_ok;
  logic                 expire;
  logic                 hold_cond;
  logic                 hold_expire;
  logic [HOLD_W-1:0]    hold_base;
  logic [TIME_BITS-1:0] age0_adv;
  logic                 done;
  logic                 ovf;
  cell_ctl_t            cell_ctl;
  logic [MAX_EVENTS-1:0] wr_en;
  logic [TIME_BITS-1:0] age_w [MAX_EVENTS+1];

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign act       = in_data.action;
  assign dt        = in_data.tick_amount;

  assign tick_go   = accept && (act == ACT_TICK) && running_r;
  assign add_ok    = accept && (act == ACT_ADD) && running_r &&
                     (count_r != CNT_W'(MAX_EVENTS));
  assign age0_adv  = age_w[0] + TIME_BITS'(dt);
  assign expire    = tick_go && !mode_r && (count_r != '0) &&
                     (AGE_CMP_W'(age0_adv) > AGE_CMP_W'(window_r));
  assign hold_cond   = CNT_CMP_W'(count_r) >= CNT_CMP_W'(reach_r);
  assign hold_base   = hold_active_r ? hold_rem_r : HOLD_W'(window_r);
  assign hold_expire = HOLD_W'(dt) >= hold_base;

  assign cell_ctl.tick  = tick_go;
  assign cell_ctl.shift = expire;
  assign cell_ctl.dt    = dt;
  assign age_w[MAX_EVENTS] = '0;

  for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
    assign wr_en[i] = add_ok && (count_r == CNT_W'(i));
    wecd_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .wr_en   (wr_en[i]),
      .nbr_age (age_w[i+1]),
      .age     (age_w[i])
    );
  end

  always_comb begin
    count_nxt       = count_r;
    running_nxt     = running_r;
    reached_nxt     = reached_r;
    hold_active_nxt = hold_active_r;
    hold_rem_nxt    = hold_rem_r;
    done            = 1'b0;
    ovf             = 1'b0;
    unique case (act)
      ACT_TICK: begin
        if (running_r) begin
          if (!mode_r) begin
            count_nxt = count_r - CNT_W'(expire);
            if (CNT_CMP_W'(count_nxt) >= CNT_CMP_W'(reach_r)) begin
              reached_nxt = 1'b1;
              running_nxt = 1'b0;
              done        = 1'b1;
            end
          end else if (hold_cond) begin
            hold_active_nxt = 1'b1;
            if (hold_expire) begin
              hold_rem_nxt = '0;
              reached_nxt  = 1'b1;
              running_nxt  = 1'b0;
              done         = 1'b1;
            end else begin
              hold_rem_nxt = hold_base - HOLD_W'(dt);
            end
          end else begin
            hold_active_nxt = 1'b0;
          end
        end
      end
      ACT_ADD: begin
        if (running_r) begin
          if (count_r == CNT_W'(MAX_EVENTS)) begin
            ovf = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ACT_DROP_NEW: begin
        if (running_r && (count_r != '0)) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_DROP_ALL: begin
        if (running_r) begin
          count_nxt = '0;
        end
      end
      ACT_START: begin
        running_nxt     = 1'b1;
        hold_active_nxt = 1'b0;
      end
      ACT_STOP: begin
        running_nxt = 1'b0;
      end
      ACT_CLEAR: begin
        count_nxt       = '0;
        running_nxt     = 1'b0;
        reached_nxt     = 1'b0;
        hold_active_nxt = 1'b0;
        hold_rem_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r      <= '0;
      reach_r       <= REACH_RESET;
      mode_r        <= 1'b0;
      count_r       <= '0;
      running_r     <= 1'b0;
      reached_r     <= 1'b0;
      hold_active_r <= 1'b0;
      hold_rem_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW: window_r <= cfg_wdata[WIN_W-1:0];
          REG_REACH:  reach_r  <= cfg_wdata[REACH_W-1:0];
          REG_MODE:   mode_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        count_r       <= count_nxt;
        running_r     <= running_nxt;
        reached_r     <= reached_nxt;
        hold_active_r <= hold_active_nxt;
        hold_rem_r    <= hold_rem_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.done_pulse  <= done;
      out_data_r.reached     <= reached_nxt;
      out_data_r.running     <= running_nxt;
      out_data_r.event_count <= EVT_W'(count_nxt);
      out_data_r.overflow    <= ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/wecd_checker.sv]
// ---------------------------------------------------------------------------
// wecd_checker
// Port-level checks of the windowed event count detector, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "windowed_event_count_detector_core_macros.svh"

module wecd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input wecd_pkg::out_t out_data
);
  import wecd_pkg::*;

  `WECD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "Result beat changed while stalled.")
  `WECD_ASSERT(a_done_stops, out_valid && out_data.done_pulse |-> out_data.reached && !out_data.running, "Done pulse without reached and stop.")
  `WECD_ASSERT(a_count_range, out_valid |-> out_data.event_count <= EVT_W'(MAX_EVENTS), "Event count beyond capacity.")
  `WECD_ASSERT(a_ovf_full, out_valid && out_data.overflow |-> out_data.event_count == EVT_W'(MAX_EVENTS) && out_data.running, "Overflow without a full store.")
  `WECD_ASSERT_ALWAYS(a_ready_when_empty, rst_n && !out_valid |-> in_ready, "Input stalled with no result pending.")

endmodule

bind windowed_event_count_detector_core wecd_checker u_wecd_checker (.*);

`default_nettype wire
